// ----- src/lz77_flagged_token_decoder_defines.svh -----
// Assertion macros shared by the LZ77 token decoder RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef LZ77_FLAGGED_TOKEN_DECODER_DEFINES_SVH
`define LZ77_FLAGGED_TOKEN_DECODER_DEFINES_SVH
`ifndef SYNTH
`define LZFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LZFD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define LZFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LZFD_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`endif
`endif

// ----- src/lzfd_pkg.sv -----
// Package for the LZ77 flagged token decoder: payload structs, FSM states,
// controller/datapath command and status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzfd_pkg;

   localparam int WINDOW_DEPTH_DEF = 65536;
   localparam int BEAT_BYTES       = 4;
   localparam int BYTE_W           = 8;
   localparam int DIST_W           = 16;
   localparam int LEN_W            = 8;
   localparam int CMP_W            = DIST_W + 1;
   localparam int KW               = $clog2(BEAT_BYTES);
   localparam int BCNT_W           = $clog2(BEAT_BYTES + 1);

   typedef struct packed {
      logic              is_match;
      logic [BYTE_W-1:0] literal;
      logic [DIST_W-1:0] distance;
      logic [LEN_W-1:0]  match_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte0;
      logic [BYTE_W-1:0] byte1;
      logic [BYTE_W-1:0] byte2;
      logic [BYTE_W-1:0] byte3;
      logic [BCNT_W-1:0] byte_count;
      logic              last_beat;
      logic              bad_distance;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   typedef struct packed {
      logic load_lit;
      logic load_err;
      logic start;
      logic issue;
      logic consume;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic tok_lit;
      logic dist_zero;
      logic dist_bad;
      logic count_zero;
      logic out_free;
      logic pend;
      logic left_zero;
      logic beat_last;
   } sts_type;

endpackage
`default_nettype wire

// ----- src/lzfd_ctrl.sv -----
// Token sequencer for the LZ77 decoder: accepts tokens and paces the copy.
// Depends on lzfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzfd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lzfd_pkg::sts_type sts_i,
   output lzfd_pkg::cmd_type cmd_o
);
   import lzfd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !sts_i.out_free;
            if (req_valid && sts_i.out_free) begin
               if (sts_i.tok_lit) begin
                  cmd_o.load_lit = 1'b1;
               end else if (!sts_i.dist_zero) begin
                  if (sts_i.dist_bad) begin
                     cmd_o.load_err = 1'b1;
                  end else if (!sts_i.count_zero) begin
                     cmd_o.start = 1'b1;
                     state_in    = ST_COPY;
                  end
               end
            end
         end
         ST_COPY: begin
            cmd_o.consume = sts_i.pend &&
                            ((!sts_i.beat_last && !sts_i.left_zero) || sts_i.out_free);
            cmd_o.flush   = cmd_o.consume && (sts_i.beat_last || sts_i.left_zero);
            cmd_o.issue   = !sts_i.left_zero && (!sts_i.pend || cmd_o.consume);
            if (cmd_o.consume && sts_i.left_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- src/lzfd_dp.sv -----
// Datapath of the LZ77 decoder: history memory, pointers, beat packing and
// the result register. Depends on lzfd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lz77_flagged_token_decoder_defines.svh"
module lzfd_dp #(
   parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lzfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lzfd_pkg::rsp_type rsp_data,
   input  lzfd_pkg::cmd_type cmd_i,
   output lzfd_pkg::sts_type sts_o
);
   import lzfd_pkg::*;

   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   logic [BYTE_W-1:0] hist_mem [WINDOW_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic [AW-1:0]     wp_ff;
   logic [AW-1:0]     src_ff;
   logic [CNT_W-1:0]  bw_ff;
   logic [LEN_W-1:0]  left_ff;
   logic              pend_ff;
   logic [KW-1:0]     k_ff;
   logic [BYTE_W-1:0] bb_ff [BEAT_BYTES];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              out_free;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic [LEN_W-1:0]  count;
   logic [CMP_W-1:0]  wp_ext;
   logic [CMP_W-1:0]  dist_ext;
   logic [CMP_W-1:0]  src_diff;
   logic [BYTE_W-1:0] beat [BEAT_BYTES];
   logic              emit;
   rsp_type           rsp_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_en    = cmd_i.load_lit || cmd_i.consume;
   assign wr_data  = cmd_i.load_lit ? req_data.literal : rdata_ff;
   assign emit     = cmd_i.load_lit || cmd_i.load_err || cmd_i.flush;

   assign count    = (DIST_W'(req_data.match_length) < req_data.distance) ?
                     req_data.match_length : req_data.distance[LEN_W-1:0];
   assign wp_ext   = CMP_W'(wp_ff);
   assign dist_ext = CMP_W'(req_data.distance);
   assign src_diff = (wp_ext >= dist_ext) ? (wp_ext - dist_ext) :
                     (wp_ext + CMP_W'(WINDOW_DEPTH) - dist_ext);

   always_comb begin
      sts_o            = '0;
      sts_o.tok_lit    = !req_data.is_match;
      sts_o.dist_zero  = (req_data.distance == '0);
      sts_o.dist_bad   = dist_ext > CMP_W'(bw_ff);
      sts_o.count_zero = (count == '0);
      sts_o.out_free   = out_free;
      sts_o.pend       = pend_ff;
      sts_o.left_zero  = (left_ff == '0);
      sts_o.beat_last  = (k_ff == KW'(BEAT_BYTES - 1));
   end

   always_comb begin
      for (int j = 0; j < BEAT_BYTES; j++) begin
         if (KW'(j) < k_ff) begin
            beat[j] = bb_ff[j];
         end else if (KW'(j) == k_ff) begin
            beat[j] = rdata_ff;
         end else begin
            beat[j] = '0;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd_i.load_lit) begin
         rsp_in.byte0      = req_data.literal;
         rsp_in.byte_count = BCNT_W'(1);
         rsp_in.last_beat  = 1'b1;
      end else if (cmd_i.load_err) begin
         rsp_in.last_beat    = 1'b1;
         rsp_in.bad_distance = 1'b1;
      end else begin
         rsp_in.byte0      = beat[0];
         rsp_in.byte1      = beat[1];
         rsp_in.byte2      = beat[2];
         rsp_in.byte3      = beat[3];
         rsp_in.byte_count = BCNT_W'(k_ff) + BCNT_W'(1);
         rsp_in.last_beat  = (left_ff == '0);
      end
   end

   // history: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wp_ff] <= wr_data;
      end
      if (cmd_i.issue) begin
         rdata_ff <= hist_mem[src_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         bw_ff        <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wp_ff <= (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
            if (bw_ff != CNT_W'(WINDOW_DEPTH)) begin
               bw_ff <= bw_ff + CNT_W'(1);
            end
         end
         if (cmd_i.start) begin
            left_ff <= count;
            k_ff    <= '0;
         end else if (cmd_i.issue) begin
            left_ff <= left_ff - LEN_W'(1);
         end
         if (cmd_i.issue) begin
            pend_ff <= 1'b1;
         end else if (cmd_i.consume) begin
            pend_ff <= 1'b0;
         end
         if (cmd_i.flush) begin
            k_ff <= '0;
         end else if (cmd_i.consume) begin
            k_ff <= k_ff + KW'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.start) begin
         src_ff <= src_diff[AW-1:0];
      end else if (cmd_i.issue) begin
         src_ff <= (src_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : src_ff + AW'(1);
      end
      if (cmd_i.consume && !cmd_i.flush) begin
         bb_ff[k_ff] <= rdata_ff;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LZFD_ASSERT_IMPL(a_consume_pend, clock, reset, cmd_i.consume, pend_ff, "consume with no byte in flight")
   `LZFD_ASSERT_IMPL(a_emit_free, clock, reset, emit, out_free, "result loaded over a pending transfer")
   `LZFD_ASSERT_IMPL(a_issue_left, clock, reset, cmd_i.issue, left_ff != '0, "read issued past copy end")
   `LZFD_ASSERT_ALWAYS(a_bw_sat, clock, reset, bw_ff <= CNT_W'(WINDOW_DEPTH), "fill count overran window")

endmodule
`default_nettype wire

// ----- src/lz77_flagged_token_decoder.sv -----
// Top level of the LZ77 flagged token decoder: sequencer plus datapath.
// Depends on lzfd_pkg, lzfd_ctrl and lzfd_dp.
//
//   channel | ports                          | payload
//   req     | req_valid, req_stall, req_data | one token (literal or match)
//   rsp     | rsp_valid, rsp_stall, rsp_data | beat of up to four bytes
//
// Literal, bad-distance and empty tokens are taken without entering the copy state.
// A match copying n bytes does one history read per cycle, held while rsp_stall blocks a beat.
// Synchronous reset clears the write pointer and fill count; history is not cleared.
// rsp_stall halts the copy once a beat is full or the copy's last byte waits; no token is taken during a copy.
`timescale 1ns / 1ps
`default_nettype none
module lz77_flagged_token_decoder #(
   parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lzfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lzfd_pkg::rsp_type rsp_data
);
   import lzfd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lzfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   lzfd_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd_i     (cmd),
      .sts_o     (sts)
   );

endmodule
`default_nettype wire

// ----- tb/lz77_token_checker.sv -----
// Checker for the LZ77 flagged token decoder: watches both channels, predicts the
// output beats of every accepted token and compares them field by field.
// Depends on lzfd_pkg.
`timescale 1ns / 1ps
module lz77_token_checker #(
   parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lzfd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lzfd_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_beats
);
   import lzfd_pkg::*;

   bit [7:0]          window_mem [WINDOW_DEPTH];
   int unsigned       wr_ptr;
   int unsigned       filled;
   lzfd_pkg::rsp_type beats_due [$];

   function automatic void push_byte(input bit [7:0] b);
      window_mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % WINDOW_DEPTH;
      if (filled < WINDOW_DEPTH) filled++;
   endfunction

   function automatic void decode_token(input lzfd_pkg::req_type tok);
      lzfd_pkg::rsp_type beat;
      bit [7:0]          lane [lzfd_pkg::BEAT_BYTES];
      int unsigned       count;
      int unsigned       src;
      int unsigned       done;
      int unsigned       k;
      beat = '0;
      if (!tok.is_match) begin
         beat.byte0      = tok.literal;
         beat.byte_count = BCNT_W'(1);
         beat.last_beat  = 1'b1;
         push_byte(tok.literal);
         beats_due.insert(beats_due.size(), beat);
         return;
      end
      if (tok.distance == 0) return;
      if (tok.distance > filled) begin
         beat.last_beat    = 1'b1;
         beat.bad_distance = 1'b1;
         beats_due.insert(beats_due.size(), beat);
         return;
      end
      // copy is clipped to the distance, so it never reads its own output
      count = (tok.match_length < tok.distance) ? tok.match_length : tok.distance;
      src   = (wr_ptr + WINDOW_DEPTH - tok.distance) % WINDOW_DEPTH;
      done  = 0;
      while (done < count) begin
         foreach (lane[i]) lane[i] = '0;
         k = 0;
         while (k < lzfd_pkg::BEAT_BYTES && done < count) begin
            lane[k] = window_mem[src];
            src = (src + 1) % WINDOW_DEPTH;
            push_byte(lane[k]);
            k++;
            done++;
         end
         beat = '0;
         beat.byte0      = lane[0];
         beat.byte1      = lane[1];
         beat.byte2      = lane[2];
         beat.byte3      = lane[3];
         beat.byte_count = BCNT_W'(k);
         beat.last_beat  = (done == count);
         beats_due.insert(beats_due.size(), beat);
      end
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      lzfd_pkg::rsp_type want;
      if (reset) begin
         wr_ptr        = 0;
         filled        = 0;
         fail_count    = 0;
         beats_due.delete();
      end else begin
         if (req_valid && !req_stall) decode_token(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               report_mismatch("unexpected transfer", 0, 1);
            end else begin
               want = beats_due[0];
               beats_due.delete(0);
               if (rsp_data.byte0 !== want.byte0)
                  report_mismatch("byte0", want.byte0, rsp_data.byte0);
               if (rsp_data.byte1 !== want.byte1)
                  report_mismatch("byte1", want.byte1, rsp_data.byte1);
               if (rsp_data.byte2 !== want.byte2)
                  report_mismatch("byte2", want.byte2, rsp_data.byte2);
               if (rsp_data.byte3 !== want.byte3)
                  report_mismatch("byte3", want.byte3, rsp_data.byte3);
               if (rsp_data.byte_count !== want.byte_count)
                  report_mismatch("byte_count", want.byte_count, rsp_data.byte_count);
               if (rsp_data.last_beat !== want.last_beat)
                  report_mismatch("last_beat", want.last_beat, rsp_data.last_beat);
               if (rsp_data.bad_distance !== want.bad_distance)
                  report_mismatch("bad_distance", want.bad_distance, rsp_data.bad_distance);
            end
         end
      end
      pending_beats = beats_due.size();
   end

endmodule

// ----- tb/lz77_flagged_token_decoder_test.sv -----
// Top of the LZ77 flagged token decoder testbench: clock, reset, token stimulus,
// output stalls, watchdog and verdict. Depends on lzfd_pkg, lz77_token_checker
// and the decoder RTL.
`timescale 1ns / 1ps
module lz77_flagged_token_decoder_test;

   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 150;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   lzfd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   lzfd_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending_beats;
   int                produced;
   int                idle_cycles;
   bit                quiet;
   bit                hold_off;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   lz77_flagged_token_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lz77_token_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   function automatic lzfd_pkg::req_type token(input bit m, input bit [7:0] lit,
                                               input bit [15:0] d, input bit [7:0] l);
      lzfd_pkg::req_type t;
      t.is_match     = m;
      t.literal      = lit;
      t.distance     = d;
      t.match_length = l;
      return t;
   endfunction

   // mostly well-formed tokens, the rest zero distance, zero length or out of range
   function automatic lzfd_pkg::req_type random_token();
      lzfd_pkg::req_type t;
      int unsigned       pick;
      int unsigned       reach;
      t.is_match     = 1'b1;
      t.literal      = 8'($urandom);
      t.distance     = 16'($urandom);
      t.match_length = 8'($urandom);
      pick  = $urandom_range(0, 99);
      reach = (produced > 65535) ? 65535 : produced;
      if (pick < 40) begin
         t.is_match = 1'b0;
      end else if (pick < 85) begin
         t.distance = ($urandom_range(0, 1) != 0) ?
                      16'($urandom_range(1, (reach < 16) ? reach : 16)) :
                      16'($urandom_range(1, reach));
         t.match_length = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                          8'($urandom_range(1, 24));
      end else if (pick < 90) begin
         t.distance = '0;
      end else if (pick < 95) begin
         t.distance     = 16'($urandom_range(1, reach));
         t.match_length = '0;
      end else if (reach < 65535) begin
         t.distance = 16'($urandom_range(reach + 1, 65535));
      end
      return t;
   endfunction

   task automatic send_token(input lzfd_pkg::req_type t);
      if (!quiet && !hold_off && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      if (!t.is_match)
         produced++;
      else if (t.distance != 0 && t.distance <= produced)
         produced += (t.match_length < t.distance) ? t.match_length : t.distance;
      @(negedge clock);
   endtask

   // output side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!reset && !quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("lz77_flagged_token_decoder_test NOT OK");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      produced  = 0;
      quiet     = 1'b0;
      hold_off  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_token(token(1'b0, 8'h00, 16'hffff, 8'hff));
      send_token(token(1'b0, 8'hff, 16'h0000, 8'h00));
      send_token(token(1'b1, 8'hff, 16'd0, 8'd5));
      send_token(token(1'b1, 8'h00, 16'd3, 8'd1));
      send_token(token(1'b1, 8'h00, 16'hffff, 8'd0));
      send_token(token(1'b0, 8'ha5, 16'h1234, 8'h00));
      send_token(token(1'b0, 8'h5a, 16'h0000, 8'h00));
      send_token(token(1'b1, 8'h00, 16'd4, 8'd0));
      send_token(token(1'b1, 8'h00, 16'd2, 8'd9));
      send_token(token(1'b1, 8'h00, 16'd6, 8'd6));
      send_token(token(1'b1, 8'h00, 16'd1, 8'd3));
      repeat (5) send_token(token(1'b1, 8'h00, 16'(produced), 8'd255));
      send_token(token(1'b1, 8'h00, 16'(produced), 8'd255));
      send_token(token(1'b1, 8'h00, 16'(produced + 1), 8'd7));
      send_token(token(1'b1, 8'h3c, 16'h8000, 8'h80));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 50) hold_off = 1'b1;
         if (n == RANDOM_ITEMS - 30) quiet = 1'b1;
         send_token(random_token());
      end
      req_valid <= 1'b0;

      while (pending_beats != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_beats == 0)
         $display("lz77_flagged_token_decoder_test OK");
      else
         $display("lz77_flagged_token_decoder_test NOT OK");
      $finish;
   end

endmodule
